[hdl/mme_pkg.sv]
// Package for the matrix multiply engine: field widths and mode codes.
// No dependencies; used by matrix_multiply_engine_core.
`default_nettype none

package mme_pkg;

	// Field widths of the input and result transactions.
	localparam int MODE_W  = 2;
	localparam int INDEX_W = 3;
	localparam int VALUE_W = 16;
	localparam int PROD_W  = 2 * VALUE_W;
	localparam int SUM_W   = 35;

	// Operation codes carried on the mode field.
	typedef logic [MODE_W-1:0] mode_t;
	localparam mode_t MODE_LOAD_A  = 2'd0;
	localparam mode_t MODE_LOAD_B  = 2'd1;
	localparam mode_t MODE_COMPUTE = 2'd2;

endpackage

`default_nettype wire

[hdl/matrix_multiply_engine_core.sv]
// Matrix multiply engine core: stores A and B in two synchronous RAMs and
// emits one row of C = A x B per compute transaction. Depends on mme_pkg.
//
// Usage:
//   An input transaction is taken at a rising edge where start is high and
//   busy is low. mode selects a load of A, a load of B, or a compute of one
//   row of C. Loads with row or col not below DIM, computes with row not
//   below DIM, and the unused mode are dropped.
//   A load leaves busy low, so loads stream back to back.
//   A compute raises busy while the sequencer issues one
//   A and one B read per cycle to the two RAMs, DIM*DIM reads in all, and a
//   single shared 16x16 multiplier plus accumulator follows behind the RAM
//   read register and the product register. That read loop sets the rate.
//   Results leave as DIM transactions, in column order, each on out_col,
//   product_sum and last for one cycle marked by strobe. The result for
//   column j is registered from the accumulator sum of its last product;
//   the final one carries last and shows in the first cycle with busy low.
//   The receiver cannot stall; every strobe cycle is taken.
//   Reset clears the sequencer and pipeline flags. RAM contents are not
//   cleared; an element must be loaded before it is used.
`default_nettype none

module matrix_multiply_engine_core #(
	parameter int DIM = 8
) (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire                                   start,
	output logic                                  busy,
	input  wire  [mme_pkg::MODE_W-1:0]            mode,
	input  wire  [mme_pkg::INDEX_W-1:0]           row,
	input  wire  [mme_pkg::INDEX_W-1:0]           col,
	input  wire  signed [mme_pkg::VALUE_W-1:0]    value,
	output logic                                  strobe,
	output logic [mme_pkg::INDEX_W-1:0]           out_col,
	output logic signed [mme_pkg::SUM_W-1:0]      product_sum,
	output logic                                  last
);

	localparam int KW    = (DIM > 1) ? $clog2(DIM) : 1;
	localparam int DEPTH = DIM * DIM;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	// Operand RAMs.
	logic signed [mme_pkg::VALUE_W-1:0] mem_a [DEPTH];
	logic signed [mme_pkg::VALUE_W-1:0] mem_b [DEPTH];

	logic          accept;
	logic          in_range;
	logic [AW-1:0] wr_addr;
	logic [AW-1:0] rd_addr_a;
	logic [AW-1:0] rd_addr_b;

	// Sequencer registers.
	logic          run_q;
	logic [KW-1:0] row_q;
	logic [KW-1:0] j_q;
	logic [KW-1:0] k_q;
	logic          k_last;
	logic          j_last;

	// Pipeline: RAM read stage, product stage.
	logic                               v_s1, first_s1, lastk_s1, lastj_s1;
	logic [KW-1:0]                      j_s1;
	logic signed [mme_pkg::VALUE_W-1:0] a_s1, b_s1;
	logic                               v_s2, first_s2, lastk_s2, lastj_s2;
	logic [KW-1:0]                      j_s2;
	logic signed [mme_pkg::PROD_W-1:0]  prod_s2;
	logic signed [mme_pkg::SUM_W-1:0]   acc_q;
	logic signed [mme_pkg::SUM_W-1:0]   sum_next;

	// Transaction decode and address generation.
	assign accept    = start && !busy;
	assign in_range  = (int'(row) < DIM) && (int'(col) < DIM);
	assign wr_addr   = AW'(KW'(row)) * AW'(DIM) + AW'(KW'(col));
	assign rd_addr_a = AW'(row_q) * AW'(DIM) + AW'(k_q);
	assign rd_addr_b = AW'(k_q) * AW'(DIM) + AW'(j_q);
	assign k_last    = (k_q == KW'(DIM - 1));
	assign j_last    = (j_q == KW'(DIM - 1));
	assign busy      = run_q || v_s1 || v_s2;

	// RAM for A: one write port for loads, one registered read port.
	always_ff @(posedge clk) begin
		if (accept && in_range && (mode == mme_pkg::MODE_LOAD_A)) begin
			mem_a[wr_addr] <= value;
		end
		a_s1 <= mem_a[rd_addr_a];
	end

	// RAM for B: one write port for loads, one registered read port.
	always_ff @(posedge clk) begin
		if (accept && in_range && (mode == mme_pkg::MODE_LOAD_B)) begin
			mem_b[wr_addr] <= value;
		end
		b_s1 <= mem_b[rd_addr_b];
	end

	// Read sequencer: k runs fastest, then j, over one row of C.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			j_q   <= '0;
			k_q   <= '0;
		end else if (accept) begin
			if ((mode == mme_pkg::MODE_COMPUTE) && (int'(row) < DIM)) begin
				run_q <= 1'b1;
				j_q   <= '0;
				k_q   <= '0;
			end
		end else if (run_q) begin
			if (k_last) begin
				k_q <= '0;
				j_q <= j_q + 1'b1;
				if (j_last) begin
					run_q <= 1'b0;
				end
			end else begin
				k_q <= k_q + 1'b1;
			end
		end
	end

	// The row index is payload and needs no reset.
	always_ff @(posedge clk) begin
		if (accept) begin
			row_q <= KW'(row);
		end
	end

	// Pipeline control flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			strobe <= 1'b0;
		end else begin
			v_s1   <= run_q;
			v_s2   <= v_s1;
			strobe <= v_s2 && lastk_s2;
		end
	end

	// Pipeline payload: tags follow the reads, the multiplier follows the RAMs.
	always_ff @(posedge clk) begin
		first_s1 <= (k_q == '0);
		lastk_s1 <= k_last;
		lastj_s1 <= j_last;
		j_s1     <= j_q;
		first_s2 <= first_s1;
		lastk_s2 <= lastk_s1;
		lastj_s2 <= lastj_s1;
		j_s2     <= j_s1;
		prod_s2  <= a_s1 * b_s1;
	end

	// Accumulate; the first term of a dot product restarts the sum.
	assign sum_next = (first_s2 ? '0 : acc_q) + mme_pkg::SUM_W'(prod_s2);

	always_ff @(posedge clk) begin
		if (v_s2) begin
			acc_q <= sum_next;
		end
		if (v_s2 && lastk_s2) begin
			product_sum <= sum_next;
			out_col     <= mme_pkg::INDEX_W'(j_s2);
			last        <= lastj_s2;
		end
	end

endmodule

`default_nettype wire

[tb/tb_matrix_multiply_engine_core.sv]
`timescale 1ns / 100ps
// Self-checking testbench for matrix_multiply_engine_core: loads A and B, requests rows of C
// and checks every emitted element against an in-bench model of the product.
// Depends on mme_pkg and matrix_multiply_engine_core.

module tb_matrix_multiply_engine_core;

	localparam int DIM = 8;
	localparam mme_pkg::mode_t MODE_UNUSED = 2'd3;
	localparam int IDLE_LIMIT = 2000;
	localparam int ITEM_TARGET = 120;

	// One command transaction as presented on the input ports.
	typedef struct {
		mme_pkg::mode_t                     mode;
		logic [mme_pkg::INDEX_W-1:0]        row;
		logic [mme_pkg::INDEX_W-1:0]        col;
		logic signed [mme_pkg::VALUE_W-1:0] value;
	} mm_cmd_t;

	// One element of a row of C as it should leave the block.
	typedef struct {
		logic [mme_pkg::INDEX_W-1:0]      col;
		logic signed [mme_pkg::SUM_W-1:0] sum;
		logic                             last;
	} c_elem_t;

	logic                               clk = 1'b0;
	logic                               arst_n = 1'b0;
	logic                               start = 1'b0;
	logic [mme_pkg::MODE_W-1:0]         mode = '0;
	logic [mme_pkg::INDEX_W-1:0]        row = '0;
	logic [mme_pkg::INDEX_W-1:0]        col = '0;
	logic signed [mme_pkg::VALUE_W-1:0] value = '0;
	wire                                busy;
	wire                                strobe;
	wire [mme_pkg::INDEX_W-1:0]         out_col;
	wire signed [mme_pkg::SUM_W-1:0]    product_sum;
	wire                                last;

	mm_cmd_t cmd_q[$];
	c_elem_t c_elem_q[$];
	mm_cmd_t drv_cmd;
	logic signed [mme_pkg::VALUE_W-1:0] mat_a [DIM][DIM];
	logic signed [mme_pkg::VALUE_W-1:0] mat_b [DIM][DIM];
	bit a_row_ok [DIM];
	logic took = 1'b0;
	logic timed_out = 1'b0;
	int unsigned gap_left = 0;
	int unsigned idle_cycles = 0;
	int unsigned error_count = 0;

	matrix_multiply_engine_core #(
		.DIM(DIM)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.mode(mode),
		.row(row),
		.col(col),
		.value(value),
		.strobe(strobe),
		.out_col(out_col),
		.product_sum(product_sum),
		.last(last)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// Counts a mismatch and prints it.
	task automatic flag_error(input string what);
		error_count++;
		$display("%0t ns: ERROR %s", $time, what);
	endtask

	// Idle gap before the next transaction: mostly none, sometimes short, rarely long.
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 4);
		return $urandom_range(5, 90);
	endfunction

	// Element value with extra weight on the extremes.
	function automatic logic signed [mme_pkg::VALUE_W-1:0] pick_value();
		case ($urandom_range(0, 7))
			0: return 16'sh8000;
			1: return 16'sh7FFF;
			2: return 16'sh0000;
			3: return 16'shFFFF;
			default: return mme_pkg::VALUE_W'($urandom);
		endcase
	endfunction

	task automatic push_cmd(input mme_pkg::mode_t m, input int r, input int c,
			input logic signed [mme_pkg::VALUE_W-1:0] v);
		mm_cmd_t cmd;
		cmd.mode = m;
		cmd.row = mme_pkg::INDEX_W'(r);
		cmd.col = mme_pkg::INDEX_W'(c);
		cmd.value = v;
		cmd_q.push_back(cmd);
	endtask

	// Compute request; column and value are don't-care and get random content.
	task automatic push_compute(input int r);
		push_cmd(mme_pkg::MODE_COMPUTE, r, $urandom_range(0, DIM - 1),
			mme_pkg::VALUE_W'($urandom));
	endtask

	// Reloads a whole row of A and marks it safe to compute.
	task automatic push_a_row(input int r);
		for (int c = 0; c < DIM; c++)
			push_cmd(mme_pkg::MODE_LOAD_A, r, c, pick_value());
		a_row_ok[r] = 1'b1;
	endtask

	// Expected row r of C = A x B, formed exactly and kept to the result width.
	function automatic void predict_c_row(input logic [mme_pkg::INDEX_W-1:0] r);
		longint acc;
		c_elem_t e;
		for (int j = 0; j < DIM; j++) begin
			acc = 0;
			for (int k = 0; k < DIM; k++)
				acc += longint'(mat_a[r][k]) * longint'(mat_b[k][j]);
			e.col = mme_pkg::INDEX_W'(j);
			e.sum = mme_pkg::SUM_W'(acc);
			e.last = (j == DIM - 1);
			c_elem_q.push_back(e);
		end
	endfunction

	// Applies one accepted command to the model matrices.
	task automatic apply_cmd();
		case (mode)
			mme_pkg::MODE_LOAD_A: begin
				if (row < DIM && col < DIM)
					mat_a[row][col] = value;
			end
			mme_pkg::MODE_LOAD_B: begin
				if (row < DIM && col < DIM)
					mat_b[row][col] = value;
			end
			mme_pkg::MODE_COMPUTE: begin
				if (row < DIM)
					predict_c_row(row);
			end
			default: begin
			end
		endcase
	endtask

	// Compares one emitted element with the oldest expected one.
	task automatic check_c_elem();
		c_elem_t e;
		if (c_elem_q.size() == 0) begin
			flag_error($sformatf("unexpected result col=%0d sum=%0d", out_col, product_sum));
			return;
		end
		e = c_elem_q.pop_front();
		if (out_col !== e.col)
			flag_error($sformatf("out_col got %0d, want %0d", out_col, e.col));
		if (product_sum !== e.sum)
			flag_error($sformatf("product_sum col %0d got %0d, want %0d",
				e.col, product_sum, e.sum));
		if (last !== e.last)
			flag_error($sformatf("last col %0d got %b, want %b", e.col, last, e.last));
	endtask

	// Driver: presents queued commands at the falling edge and holds each until taken.
	always @(negedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else if (!start || took) begin
			if (gap_left != 0) begin
				gap_left <= gap_left - 1;
				start <= 1'b0;
				mode <= mme_pkg::MODE_W'($urandom);
				row <= mme_pkg::INDEX_W'($urandom);
				col <= mme_pkg::INDEX_W'($urandom);
				value <= mme_pkg::VALUE_W'($urandom);
			end else if (cmd_q.size() != 0) begin
				drv_cmd = cmd_q.pop_front();
				mode <= drv_cmd.mode;
				row <= drv_cmd.row;
				col <= drv_cmd.col;
				value <= drv_cmd.value;
				start <= 1'b1;
				gap_left <= pick_gap();
			end else begin
				start <= 1'b0;
			end
		end
	end

	// Monitor: takes commands into the model and checks results at the rising edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			took <= 1'b0;
		end else begin
			took <= start && !busy;
			if (start && !busy)
				apply_cmd();
			if (strobe)
				check_c_elem();
		end
	end

	// Watchdog: flags a run where no transaction moves for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || strobe)
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT)
				timed_out <= 1'b1;
		end
	end

	// Stimulus, reset and end of run.
	initial begin
		// Largest positive sum: every operand at the most negative value.
		for (int r = 0; r < DIM; r++)
			for (int c = 0; c < DIM; c++)
				push_cmd(mme_pkg::MODE_LOAD_B, r, c, 16'sh8000);
		for (int c = 0; c < DIM; c++)
			push_cmd(mme_pkg::MODE_LOAD_A, 0, c, 16'sh8000);
		a_row_ok[0] = 1'b1;
		push_compute(0);
		// Most negative sum: largest positive A against most negative B.
		for (int c = 0; c < DIM; c++)
			push_cmd(mme_pkg::MODE_LOAD_A, 1, c, 16'sh7FFF);
		a_row_ok[1] = 1'b1;
		push_compute(1);
		// The unused mode must leave A untouched.
		push_cmd(MODE_UNUSED, 0, 0, 16'sh0000);
		push_compute(0);
		// The highest row of A.
		push_a_row(DIM - 1);
		push_compute(DIM - 1);

		// Random mix of loads, computes, row reloads and unused-mode noise.
		// Only rows of A that were loaded in full are computed.
		while (cmd_q.size() < ITEM_TARGET) begin
			int unsigned pick;
			int r;
			pick = $urandom_range(0, 99);
			r = $urandom_range(0, DIM - 1);
			if (pick < 30) begin
				push_cmd(mme_pkg::MODE_LOAD_A, r, $urandom_range(0, DIM - 1), pick_value());
			end else if (pick < 50) begin
				push_cmd(mme_pkg::MODE_LOAD_B, r, $urandom_range(0, DIM - 1), pick_value());
			end else if (pick < 75) begin
				if (a_row_ok[r])
					push_compute(r);
				else
					push_compute(0);
			end else if (pick < 90) begin
				push_a_row(r);
				push_compute(r);
			end else begin
				push_cmd(MODE_UNUSED, r, $urandom_range(0, DIM - 1),
					mme_pkg::VALUE_W'($urandom));
			end
		end

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (!timed_out && (cmd_q.size() != 0 || start || c_elem_q.size() != 0))
			@(negedge clk);
		if (!timed_out)
			repeat (3 * DIM) @(negedge clk);

		if (!timed_out && error_count == 0)
			$display("tb_matrix_multiply_engine_core passed");
		else
			$display("tb_matrix_multiply_engine_core failed");
		$finish;
	end

endmodule

[filelist.f]
hdl/mme_pkg.sv
hdl/matrix_multiply_engine_core.sv
tb/tb_matrix_multiply_engine_core.sv
